>>> rtl/crcfr_pkg.sv
`default_nettype none

package crcfr_pkg;

  localparam int unsigned FRAME_LAST = 8;
  localparam int unsigned CRC_SPAN   = 7;
  localparam int unsigned PAY_FIRST  = 3;
  localparam int unsigned PAY_LAST   = 6;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic {
    REQ_BYTE  = 1'b0,
    REQ_REARM = 1'b1
  } req_t;

  // One byte of reflected CRC-16, least significant bit first.
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/crc_checked_frame_receiver.sv
// A request is registered at acceptance and resolved when it leaves the input register;
// a frame result is registered in the result register when its last byte leaves the input register.
// Throughput: one request per cycle; only the output register stalling slows intake.
// Reset (synchronous, active low) arms the receiver, clears the frame position,
// loads the CRC with 0xFFFF and clears the stored payload and the updated flag.
`default_nettype none

module crc_checked_frame_receiver
  import crcfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_crc_ok,
  output logic [31:0]      out_payload,
  output logic             out_updated
);

  // Input register
  logic       s1_valid_r;
  req_t       s1_req_r;
  logic [7:0] s1_byte_r;

  // Receiver state
  logic        armed_r,     armed_nxt;
  logic [3:0]  byte_idx_r,  byte_idx_nxt;
  logic [15:0] crc_r,       crc_nxt;
  logic [7:0]  crc_low_r,   crc_low_nxt;
  logic [31:0] pend_r,      pend_nxt;
  logic [31:0] good_r,      good_nxt;
  logic        upd_flag_r,  upd_flag_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r,    out_ok_nxt;
  logic [31:0] out_pay_r,   out_pay_nxt;
  logic        out_upd_r,   out_upd_nxt;

  logic advance;
  logic in_take;
  logic frame_ok;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign frame_ok = (crc_r[7:0] == crc_low_r) && (crc_r[15:8] == s1_byte_r);

  always_comb begin
    armed_nxt     = armed_r;
    byte_idx_nxt  = byte_idx_r;
    crc_nxt       = crc_r;
    crc_low_nxt   = crc_low_r;
    pend_nxt      = pend_r;
    good_nxt      = good_r;
    upd_flag_nxt  = upd_flag_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_pay_nxt   = out_pay_r;
    out_upd_nxt   = out_upd_r;
    if (advance) begin
      out_valid_nxt = 1'b0;
      if (s1_req_r == REQ_REARM) begin
        armed_nxt = 1'b1;
      end else if (armed_r) begin
        if (byte_idx_r >= 4'(FRAME_LAST)) begin
          if (frame_ok) begin
            good_nxt     = pend_r;
            upd_flag_nxt = 1'b1;
          end
          armed_nxt     = 1'b0;
          byte_idx_nxt  = '0;
          crc_nxt       = CRC_INIT;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = frame_ok;
          out_pay_nxt   = frame_ok ? pend_r : good_r;
          out_upd_nxt   = frame_ok || upd_flag_r;
        end else begin
          if (byte_idx_r < 4'(CRC_SPAN)) begin
            crc_nxt = crc_add_byte(crc_r, s1_byte_r);
          end
          // Payload bytes arrive in order, so shifting in leaves byte 3 on top.
          if (byte_idx_r >= 4'(PAY_FIRST) && byte_idx_r <= 4'(PAY_LAST)) begin
            pend_nxt = {pend_r[23:0], s1_byte_r};
          end
          if (byte_idx_r == 4'(CRC_SPAN)) begin
            crc_low_nxt = s1_byte_r;
          end
          byte_idx_nxt = byte_idx_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      armed_r     <= 1'b1;
      byte_idx_r  <= '0;
      crc_r       <= CRC_INIT;
      good_r      <= '0;
      upd_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      armed_r     <= armed_nxt;
      byte_idx_r  <= byte_idx_nxt;
      crc_r       <= crc_nxt;
      good_r      <= good_nxt;
      upd_flag_r  <= upd_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r  <= req_t'(in_req_type);
      s1_byte_r <= in_rx_byte;
    end
    crc_low_r <= crc_low_nxt;
    pend_r    <= pend_nxt;
    out_ok_r  <= out_ok_nxt;
    out_pay_r <= out_pay_nxt;
    out_upd_r <= out_upd_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_crc_ok  = out_ok_r;
  assign out_payload = out_pay_r;
  assign out_updated = out_upd_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= 4'(FRAME_LAST))
    else $error("frame position beyond last byte");

  a_disarmed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (byte_idx_r == '0) && (crc_r == CRC_INIT))
    else $error("disarmed receiver holds a partial frame");

  a_no_payload_before_pass: assert property (@(posedge clk) disable iff (!rst_n)
    !upd_flag_r |-> good_r == '0)
    else $error("payload stored without a passing frame");

  a_result_from_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(byte_idx_r) == 4'(FRAME_LAST) && !armed_r)
    else $error("result without a completed frame");

  a_ok_sets_updated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ok_r |-> out_upd_r && upd_flag_r)
    else $error("passing frame did not set the updated flag");

endmodule

`default_nettype wire

>>> tb/tb_crc_checked_frame_receiver.sv
`timescale 1ns / 100ps

module tb_crc_checked_frame_receiver;
  import crcfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 10;

  typedef enum logic [2:0] {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_HOLD
  } phase_t;

  typedef struct {
    req_t       kind;
    logic [7:0] data;
    phase_t     phase;
    bit         drain;
  } rx_request_t;

  typedef struct {
    logic        crc_ok;
    logic [31:0] payload;
    logic        updated;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_crc_ok;
  logic [31:0] out_payload;
  logic        out_updated;

  rx_request_t   pending_requests[$];
  frame_result_t expected_frames[$];

  phase_t cur_phase = PH_FREE;
  int     idle_pct;
  int     stall_pct;
  int     errors = 0;
  int     quiet_cycles = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  int     cycle_count = 0;

  // Predicted receiver state.
  logic        p_armed = 1'b1;
  logic [3:0]  p_index = 4'd0;
  logic [15:0] p_crc = CRC_INIT;
  logic [7:0]  p_crc_low = 8'h00;
  logic [31:0] p_pending = 32'h0;
  logic [31:0] p_good = 32'h0;
  logic        p_updated = 1'b0;

  crc_checked_frame_receiver u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_crc_ok  (out_crc_ok),
    .out_payload (out_payload),
    .out_updated (out_updated)
  );

  always #5 clk = ~clk;

  // Bitwise form of the reflected CRC-16: each data bit, least significant first,
  // is folded into the low end of the register before the shift.
  function automatic logic [15:0] frame_crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      acc = (acc[0] ^ b[i]) ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic void track_request(req_t kind, logic [7:0] b);
    frame_result_t r;
    if (kind == REQ_REARM) begin
      p_armed = 1'b1;
      return;
    end
    if (!p_armed) begin
      return;
    end
    if (p_index >= FRAME_LAST) begin
      r.crc_ok = (p_crc[7:0] == p_crc_low) && (p_crc[15:8] == b);
      if (r.crc_ok) begin
        p_good = p_pending;
        p_updated = 1'b1;
      end
      r.payload = p_good;
      r.updated = p_updated;
      expected_frames.push_back(r);
      p_armed = 1'b0;
      p_index = 4'd0;
      p_crc = CRC_INIT;
      return;
    end
    if (p_index < CRC_SPAN) begin
      p_crc = frame_crc_step(p_crc, b);
    end
    if (p_index >= PAY_FIRST && p_index <= PAY_LAST) begin
      p_pending[8 * (PAY_LAST - p_index) +: 8] = b;
    end
    if (p_index == CRC_SPAN) begin
      p_crc_low = b;
    end
    p_index = p_index + 4'd1;
  endfunction

  task automatic add_request(req_t kind, logic [7:0] data, phase_t ph);
    rx_request_t r;
    r.kind = kind;
    r.data = data;
    r.phase = ph;
    r.drain = 1'b0;
    pending_requests.push_back(r);
  endtask

  // fill < 0 gives random frame bytes, otherwise every data byte takes that value.
  task automatic add_frame(phase_t ph, bit good, int fill, bit rearm);
    logic [7:0]  fb[9];
    logic [15:0] crc;
    int          mode;
    crc = CRC_INIT;
    for (int i = 0; i < CRC_SPAN; i++) begin
      fb[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
      crc = frame_crc_step(crc, fb[i]);
    end
    fb[7] = crc[7:0];
    fb[8] = crc[15:8];
    if (!good) begin
      mode = $urandom_range(2);
      if (mode != 1) begin
        fb[7] = fb[7] ^ 8'($urandom_range(255, 1));
      end
      if (mode != 0) begin
        fb[8] = fb[8] ^ 8'($urandom_range(255, 1));
      end
    end
    for (int i = 0; i <= FRAME_LAST; i++) begin
      add_request(REQ_BYTE, fb[i], ph);
    end
    if (rearm) begin
      add_request(REQ_REARM, 8'($urandom), ph);
    end
  endtask

  // Mostly well-formed frames with random content; the rest is loose bytes,
  // stray rearms and cut-off frames that knock the framing out of step.
  task automatic add_phase(phase_t ph, int n_items);
    int start;
    int roll;
    start = pending_requests.size();
    while (pending_requests.size() - start < n_items) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        add_frame(ph, roll < 56, -1, 1'b1);
      end else if (roll < 88) begin
        repeat ($urandom_range(8, 1)) add_request(REQ_BYTE, 8'($urandom), ph);
        add_request(REQ_REARM, 8'($urandom), ph);
      end else begin
        repeat ($urandom_range(12, 1)) begin
          if ($urandom_range(3) == 0) begin
            add_request(REQ_REARM, 8'($urandom), ph);
          end else begin
            case ($urandom_range(9))
              0: add_request(REQ_BYTE, 8'h00, ph);
              1: add_request(REQ_BYTE, 8'hFF, ph);
              default: add_request(REQ_BYTE, 8'($urandom), ph);
            endcase
          end
        end
      end
    end
    // The sender waits for the block to empty before the phase begins.
    pending_requests[start].drain = 1'b1;
  endtask

  always_comb begin
    case (cur_phase)
      PH_SEND_IDLE: begin
        idle_pct = 46;
        stall_pct = 0;
      end
      PH_RECV_STALL: begin
        idle_pct = 0;
        stall_pct = 46;
      end
      PH_BOTH: begin
        idle_pct = 16;
        stall_pct = 16;
      end
      default: begin
        idle_pct = 0;
        stall_pct = 0;
      end
    endcase
  end

  // Request driver.
  always @(posedge clk) begin
    rx_request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_request(req_t'(in_req_type), in_rx_byte);
      end
      if (expected_frames.size() == 0) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_requests[0].drain &&
                     (expected_frames.size() != 0 || quiet_cycles < 4)) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(99) < idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_req_type <= req.kind;
          in_rx_byte <= req.data;
          cur_phase <= req.phase;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    frame_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected frame result crc_ok=%0b payload=%h updated=%0b",
                   $time, out_crc_ok, out_payload, out_updated);
          errors++;
        end else begin
          e = expected_frames.pop_front();
          if (out_crc_ok !== e.crc_ok) begin
            $display("%0t: crc_ok mismatch, expected %0b, got %0b",
                     $time, e.crc_ok, out_crc_ok);
            errors++;
          end
          if (out_payload !== e.payload) begin
            $display("%0t: payload mismatch, expected %h, got %h",
                     $time, e.payload, out_payload);
            errors++;
          end
          if (out_updated !== e.updated) begin
            $display("%0t: updated mismatch, expected %0b, got %0b",
                     $time, e.updated, out_updated);
            errors++;
          end
        end
      end
      // One long hold-off while the sender keeps going, so the block backs up.
      if (cur_phase == PH_HOLD && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("crc_checked_frame_receiver regression: fail");
    $finish;
  end

  initial begin
    // A failing frame straight after reset shows the cleared payload and flag.
    add_frame(PH_FREE, 1'b0, 8'h00, 1'b0);
    // Bytes while disarmed are dropped.
    add_request(REQ_BYTE, 8'hFF, PH_FREE);
    add_request(REQ_BYTE, 8'h00, PH_FREE);
    // Rearm, then a rearm while already armed.
    add_request(REQ_REARM, 8'h00, PH_FREE);
    add_request(REQ_REARM, 8'hFF, PH_FREE);
    add_frame(PH_FREE, 1'b1, 8'hFF, 1'b1);

    add_phase(PH_FREE, 180);
    add_phase(PH_SEND_IDLE, 180);
    add_phase(PH_RECV_STALL, 180);
    add_phase(PH_BOTH, 180);
    add_phase(PH_HOLD, 120);
    add_phase(PH_FREE, 80);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("crc_checked_frame_receiver regression: pass");
    end else begin
      $display("crc_checked_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule
